// File: hdl/vna_pkg.sv
// ----------------------------------------------------------------------------
// Vertex normal accumulator package
// Shared types, codes and widths for the vertex normal accumulator.
// ----------------------------------------------------------------------------
package vna_pkg;

    localparam int IDX_W                = 10;
    localparam int DEFAULT_VERTEX_COUNT = 1024;
    localparam int DEFAULT_COORD_BITS   = 16;
    localparam int SUM_W                = 24;
    localparam int NORM_W               = 16;
    localparam int QUO_W                = 15;
    localparam int NUM_W                = 46;
    localparam int ROOT_W               = 32;
    localparam int RAD_W                = 64;
    localparam int MUL_W                = 32;
    localparam int UNIT_SHIFT           = 14;
    localparam int IN_DATA_W            = 80;
    localparam int OUT_DATA_W           = 48;

    localparam logic [1:0] OP_WRITE    = 2'd0;
    localparam logic [1:0] OP_TRIANGLE = 2'd1;
    localparam logic [1:0] OP_READ     = 2'd2;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_PRD_A,
        S_PRD_B,
        S_PRD_C,
        S_EDGE,
        S_CROSS,
        S_CMAG,
        S_RRD,
        S_RLD,
        S_NSCALE,
        S_NSQ,
        S_SQ_GO,
        S_SQ_WAIT,
        S_DV_GO,
        S_DV_WAIT,
        S_FIN,
        S_RMW_RD,
        S_RMW_WR,
        S_OUT
    } t_state;

    typedef struct packed {
        logic start;
    } t_iter_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_iter_sts;

endpackage

// File: hdl/vna_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// Signed 32 by 32 multiplier with a registered product.
// ----------------------------------------------------------------------------
module vna_mul
    import vna_pkg::*;
(
    input  logic                        i_clk,
    input  logic signed [MUL_W-1:0]     i_op_a,
    input  logic signed [MUL_W-1:0]     i_op_b,
    output logic signed [2*MUL_W-1:0]   o_prod
);

    logic signed [2*MUL_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

// File: hdl/vna_isqrt.sv
// ----------------------------------------------------------------------------
// Iterative integer square root
// Floor square root of a 64-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module vna_isqrt
    import vna_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_iter_ctl           i_ctl,
    input  logic [RAD_W-1:0]    i_radicand,
    output t_iter_sts           o_sts,
    output logic [ROOT_W-1:0]   o_root
);

    logic             r_busy;
    logic             r_done;
    logic [RAD_W-1:0] r_rem;
    logic [RAD_W-1:0] r_res;
    logic [RAD_W-1:0] r_bit;
    logic [RAD_W-1:0] trial;

    assign trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit == RAD_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_radicand;
            r_res <= '0;
            r_bit <= RAD_W'(1) << (RAD_W - 2);
        end else if (r_busy) begin
            if (r_rem >= trial) begin
                r_rem <= r_rem - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_root     = r_res[ROOT_W-1:0];

endmodule

// File: hdl/vna_div.sv
// ----------------------------------------------------------------------------
// Iterative divider
// Restoring division giving a 15-bit quotient, one bit per cycle.
// ----------------------------------------------------------------------------
module vna_div
    import vna_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_iter_ctl           i_ctl,
    input  logic [NUM_W-1:0]    i_num,
    input  logic [ROOT_W-1:0]   i_den,
    output t_iter_sts           o_sts,
    output logic [QUO_W-1:0]    o_quo
);

    localparam int CNT_W = $clog2(QUO_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [QUO_W-1:0] r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(QUO_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem <= i_num;
            r_den <= NUM_W'(i_den) << (QUO_W - 1);
            r_quo <= '0;
        end else if (r_busy) begin
            if (r_rem >= r_den) begin
                r_rem <= r_rem - r_den;
                r_quo <= {r_quo[QUO_W-2:0], 1'b1};
            end else begin
                r_quo <= {r_quo[QUO_W-2:0], 1'b0};
            end
            r_den <= r_den >> 1;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quo      = r_quo;

endmodule

// File: hdl/vertex_normal_accumulator.sv
// A write completes when it is accepted. A triangle or a read keeps the sequencer busy
// through the scaling, square root and divisions, and a read also waits out any output
// stall; a degenerate face, a zero sum or an out-of-range read index skips those steps.
// The scaling shift moves one bit per cycle; the 32-step square root and three
// 15-step divisions share one multiplier, root unit and divider.
// Throughput: one item at a time; the next item is accepted once the sequencer is idle.
// Reset: synchronous, active low; afterwards a clearing pass over min(VERTEX_COUNT, 1024)
// entries zeroes the normal sums, and no word is accepted until it ends.
// ----------------------------------------------------------------------------
// Vertex normal accumulator
// Accumulates unit face normals of indexed triangles into per-vertex sums and returns them normalized on a read.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator
    import vna_pkg::*;
#(
    parameter int VERTEX_COUNT = DEFAULT_VERTEX_COUNT,
    parameter int COORD_BITS   = DEFAULT_COORD_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // corner_a, corner_b, corner_c, pos_x, pos_y, pos_z, zero fill
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // norm_x, norm_y, norm_z
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                   m_axis_tuser
);

    localparam int C     = COORD_BITS;
    localparam int EW    = C + 1;
    localparam int CW    = 2 * EW + 1;
    localparam int MW    = (CW > 31) ? CW : 31;
    localparam int DEPTH = (VERTEX_COUNT > 1024) ? 1024 : VERTEX_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [MW:0] LIM_HI = (MW + 1)'(1) << 31;
    localparam logic [MW:0] LIM_LO = (MW + 1)'(1) << 30;
    localparam logic signed [SUM_W:0] SAT_HI = (SUM_W + 1)'((1 << (SUM_W - 1)) - 1);
    localparam logic signed [SUM_W:0] SAT_LO = -((SUM_W + 1)'(1 << (SUM_W - 1)));

    t_state r_state, n_state;

    logic [C*3-1:0]       pos_mem [DEPTH];
    logic [SUM_W*3-1:0]   sum_mem [DEPTH];
    logic [C*3-1:0]       r_pos_rd;
    logic [SUM_W*3-1:0]   r_sum_rd;

    logic                 pos_we;
    logic [AW-1:0]        pos_waddr, pos_raddr;
    logic [C*3-1:0]       pos_wdata;
    logic                 sum_we;
    logic [AW-1:0]        sum_waddr, sum_raddr;
    logic [SUM_W*3-1:0]   sum_wdata;

    logic [AW-1:0]        r_clr;
    logic [1:0]           r_op;
    logic [IDX_W-1:0]     r_a, r_b, r_c;
    logic                 r_bad;
    logic [2:0]           r_step;
    logic [1:0]           r_comp;
    logic [C*3-1:0]       r_pa, r_pb;
    logic signed [EW-1:0] r_e1 [3];
    logic signed [EW-1:0] r_e2 [3];
    logic signed [CW-1:0] r_cr [3];
    logic [MW-1:0]        r_mag [3];
    logic                 r_neg [3];
    logic [RAD_W-1:0]     r_s;
    logic [ROOT_W-1:0]    r_root;
    logic signed [NORM_W-1:0] r_n [3];
    logic                 r_degen;
    logic                 r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;
    logic                 r_m_user;

    logic                 s_acc;
    logic [1:0]           in_op;
    logic [IDX_W-1:0]     in_a, in_b, in_c;
    logic                 ok_a, ok_b, ok_c;
    logic [MW-1:0]        mag_max;
    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [2*MUL_W-1:0] mul_p;
    t_iter_ctl            sq_ctl, dv_ctl;
    t_iter_sts            sq_sts, dv_sts;
    logic [ROOT_W-1:0]    sq_root;
    logic [QUO_W-1:0]     dv_q;
    logic [NUM_W-1:0]     dv_num;
    logic [IDX_W-1:0]     rmw_idx;

    function automatic logic signed [C-1:0] coord(input logic [15:0] v);
        return C'($signed(v));
    endfunction

    function automatic logic signed [EW-1:0] pcomp(input logic [C*3-1:0] p, input int k);
        return EW'($signed(p[k*C +: C]));
    endfunction

    function automatic logic signed [MUL_W-1:0] sx(input logic signed [EW-1:0] v);
        return MUL_W'(v);
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic signed [NORM_W-1:0] d);
        logic signed [SUM_W:0] t;
        t = (SUM_W + 1)'($signed(s)) + (SUM_W + 1)'(d);
        if (t > SAT_HI) begin
            t = SAT_HI;
        end else if (t < SAT_LO) begin
            t = SAT_LO;
        end
        return t[SUM_W-1:0];
    endfunction

    function automatic logic [MW-1:0] abs_sum(input logic [SUM_W-1:0] v);
        logic [SUM_W-1:0] a;
        a = v[SUM_W-1] ? (SUM_W'(0) - v) : v;
        return MW'(a);
    endfunction

    assign in_op = s_axis_tuser;
    assign in_a  = s_axis_tdata[9:0];
    assign in_b  = s_axis_tdata[19:10];
    assign in_c  = s_axis_tdata[29:20];
    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign ok_a  = 17'(in_a) < 17'(VERTEX_COUNT);
    assign ok_b  = 17'(in_b) < 17'(VERTEX_COUNT);
    assign ok_c  = 17'(in_c) < 17'(VERTEX_COUNT);

    always_comb begin
        mag_max = r_mag[0];
        if (r_mag[1] > mag_max) begin
            mag_max = r_mag[1];
        end
        if (r_mag[2] > mag_max) begin
            mag_max = r_mag[2];
        end
    end

    assign dv_num = NUM_W'({r_mag[r_comp][30:0], UNIT_SHIFT'(0)}) + NUM_W'(r_root[ROOT_W-1:1]);

    vna_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (mul_a),
        .i_op_b (mul_b),
        .o_prod (mul_p)
    );

    vna_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (sq_ctl),
        .i_radicand (r_s),
        .o_sts      (sq_sts),
        .o_root     (sq_root)
    );

    vna_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (dv_ctl),
        .i_num   (dv_num),
        .i_den   (r_root),
        .o_sts   (dv_sts),
        .o_quo   (dv_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        pos_we        = 1'b0;
        pos_waddr     = in_a[AW-1:0];
        pos_wdata     = {coord(s_axis_tdata[77:62]), coord(s_axis_tdata[61:46]),
                         coord(s_axis_tdata[45:30])};
        pos_raddr     = r_a[AW-1:0];
        sum_we        = 1'b0;
        sum_waddr     = in_a[AW-1:0];
        sum_wdata     = '0;
        sum_raddr     = r_a[AW-1:0];
        mul_a         = '0;
        mul_b         = '0;
        sq_ctl.start  = 1'b0;
        dv_ctl.start  = 1'b0;
        case (r_comp)
            2'd1:    rmw_idx = r_b;
            2'd2:    rmw_idx = r_c;
            default: rmw_idx = r_a;
        endcase
        case (r_state)
            S_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = r_clr;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    case (in_op)
                        OP_WRITE: begin
                            pos_we = ok_a;
                            sum_we = ok_a;
                        end
                        OP_TRIANGLE: begin
                            if (ok_a && ok_b && ok_c) begin
                                n_state = S_PRD_A;
                            end
                        end
                        OP_READ: n_state = S_RRD;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_PRD_A: begin
                n_state = S_PRD_B;
            end
            S_PRD_B: begin
                pos_raddr = r_b[AW-1:0];
                n_state   = S_PRD_C;
            end
            S_PRD_C: begin
                pos_raddr = r_c[AW-1:0];
                n_state   = S_EDGE;
            end
            S_EDGE: n_state = S_CROSS;
            S_CROSS: begin
                case (r_step)
                    3'd0: begin mul_a = sx(r_e1[1]); mul_b = sx(r_e2[2]); end
                    3'd1: begin mul_a = sx(r_e1[2]); mul_b = sx(r_e2[1]); end
                    3'd2: begin mul_a = sx(r_e1[2]); mul_b = sx(r_e2[0]); end
                    3'd3: begin mul_a = sx(r_e1[0]); mul_b = sx(r_e2[2]); end
                    3'd4: begin mul_a = sx(r_e1[0]); mul_b = sx(r_e2[1]); end
                    3'd5: begin mul_a = sx(r_e1[1]); mul_b = sx(r_e2[0]); end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (r_step == 3'd6) begin
                    n_state = S_CMAG;
                end
            end
            S_CMAG: n_state = S_NSCALE;
            S_RRD:  n_state = S_RLD;
            S_RLD:  n_state = S_NSCALE;
            S_NSCALE: begin
                if (mag_max == '0) begin
                    n_state = S_FIN;
                end else if ({1'b0, mag_max} >= LIM_LO && {1'b0, mag_max} < LIM_HI) begin
                    n_state = S_NSQ;
                end
            end
            S_NSQ: begin
                case (r_step)
                    3'd0: begin mul_a = {1'b0, r_mag[0][30:0]}; mul_b = {1'b0, r_mag[0][30:0]}; end
                    3'd1: begin mul_a = {1'b0, r_mag[1][30:0]}; mul_b = {1'b0, r_mag[1][30:0]}; end
                    3'd2: begin mul_a = {1'b0, r_mag[2][30:0]}; mul_b = {1'b0, r_mag[2][30:0]}; end
                    default: begin mul_a = '0; mul_b = '0; end
                endcase
                if (r_step == 3'd3) begin
                    n_state = S_SQ_GO;
                end
            end
            S_SQ_GO: begin
                sq_ctl.start = 1'b1;
                n_state      = S_SQ_WAIT;
            end
            S_SQ_WAIT: begin
                if (sq_sts.done) begin
                    n_state = S_DV_GO;
                end
            end
            S_DV_GO: begin
                dv_ctl.start = 1'b1;
                n_state      = S_DV_WAIT;
            end
            S_DV_WAIT: begin
                if (dv_sts.done) begin
                    n_state = (r_comp == 2'd2) ? S_FIN : S_DV_GO;
                end
            end
            S_FIN: n_state = (r_op == OP_READ) ? S_OUT : S_RMW_RD;
            S_RMW_RD: begin
                sum_raddr = rmw_idx[AW-1:0];
                n_state   = S_RMW_WR;
            end
            S_RMW_WR: begin
                sum_we    = 1'b1;
                sum_waddr = rmw_idx[AW-1:0];
                sum_wdata = {sat_add(r_sum_rd[71:48], r_n[2]),
                             sat_add(r_sum_rd[47:24], r_n[1]),
                             sat_add(r_sum_rd[23:0], r_n[0])};
                n_state   = (r_comp == 2'd2) ? S_IDLE : S_RMW_RD;
            end
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            pos_mem[pos_waddr] <= pos_wdata;
        end
        r_pos_rd <= pos_mem[pos_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (sum_we) begin
            sum_mem[sum_waddr] <= sum_wdata;
        end
        r_sum_rd <= sum_mem[sum_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == S_OUT && (!r_m_valid || m_axis_tready)) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_op  <= in_op;
            r_a   <= in_a;
            r_b   <= in_b;
            r_c   <= in_c;
            r_bad <= !ok_a;
        end
        case (r_state)
            S_PRD_B: r_pa <= r_pos_rd;
            S_PRD_C: r_pb <= r_pos_rd;
            S_EDGE: begin
                for (int k = 0; k < 3; k++) begin
                    r_e1[k] <= pcomp(r_pb, k) - pcomp(r_pa, k);
                    r_e2[k] <= pcomp(r_pos_rd, k) - pcomp(r_pa, k);
                end
                r_step <= '0;
            end
            S_CROSS: begin
                r_step <= r_step + 3'd1;
                case (r_step)
                    3'd1: r_cr[0] <= mul_p[CW-1:0];
                    3'd2: r_cr[0] <= r_cr[0] - mul_p[CW-1:0];
                    3'd3: r_cr[1] <= mul_p[CW-1:0];
                    3'd4: r_cr[1] <= r_cr[1] - mul_p[CW-1:0];
                    3'd5: r_cr[2] <= mul_p[CW-1:0];
                    3'd6: r_cr[2] <= r_cr[2] - mul_p[CW-1:0];
                    default: r_cr[0] <= r_cr[0];
                endcase
            end
            S_CMAG: begin
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= r_cr[k][CW-1];
                    r_mag[k] <= MW'(r_cr[k][CW-1] ? (CW'(0) - r_cr[k]) : r_cr[k]);
                end
            end
            S_RLD: begin
                r_neg[0] <= r_sum_rd[23]  && !r_bad;
                r_neg[1] <= r_sum_rd[47]  && !r_bad;
                r_neg[2] <= r_sum_rd[71]  && !r_bad;
                r_mag[0] <= r_bad ? '0 : abs_sum(r_sum_rd[23:0]);
                r_mag[1] <= r_bad ? '0 : abs_sum(r_sum_rd[47:24]);
                r_mag[2] <= r_bad ? '0 : abs_sum(r_sum_rd[71:48]);
            end
            S_NSCALE: begin
                r_step <= '0;
                r_comp <= '0;
                if (mag_max == '0) begin
                    r_degen <= 1'b1;
                    for (int k = 0; k < 3; k++) begin
                        r_n[k] <= '0;
                    end
                end else begin
                    r_degen <= 1'b0;
                    if ({1'b0, mag_max} >= LIM_HI) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] >> 1;
                        end
                    end else if ({1'b0, mag_max} < LIM_LO) begin
                        for (int k = 0; k < 3; k++) begin
                            r_mag[k] <= r_mag[k] << 1;
                        end
                    end
                end
            end
            S_NSQ: begin
                r_step <= r_step + 3'd1;
                if (r_step == 3'd0) begin
                    r_s <= '0;
                end else begin
                    r_s <= r_s + RAD_W'(mul_p);
                end
            end
            S_SQ_WAIT: begin
                if (sq_sts.done) begin
                    r_root <= sq_root;
                end
            end
            S_DV_WAIT: begin
                if (dv_sts.done) begin
                    r_n[r_comp] <= r_neg[r_comp] ? (NORM_W'(0) - NORM_W'(dv_q))
                                                 : NORM_W'(dv_q);
                    r_comp <= r_comp + 2'd1;
                end
            end
            S_FIN: r_comp <= '0;
            S_RMW_WR: r_comp <= r_comp + 2'd1;
            S_OUT: begin
                if (!r_m_valid || m_axis_tready) begin
                    r_m_data <= {r_n[2], r_n[1], r_n[0]};
                    r_m_user <= r_degen;
                end
            end
            default: r_step <= r_step;
        endcase
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef NO_ASSERTIONS
    a_root_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        sq_sts.done |-> sq_root[ROOT_W-1:ROOT_W-2] != 2'b00)
        else $error("Square root of a scaled vector fell below the expected range.");

    a_quo_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_sts.done |-> dv_q <= QUO_W'(16384))
        else $error("Normalized component exceeds unit length.");

    a_scaled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NSQ) |-> ({1'b0, mag_max} >= LIM_LO && {1'b0, mag_max} < LIM_HI))
        else $error("Squares started before the vector was scaled.");

    a_units_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tready |-> (!sq_sts.busy && !dv_sts.busy))
        else $error("A word was accepted while an iterative unit was busy.");
`endif

endmodule

// File: tb/sv/vertex_normal_accumulator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Vertex normal accumulator testbench
// Drives position writes, triangles and reads on the input stream, predicts
// every read word from its own copy of the position and normal-sum stores,
// and compares it with each word on the output stream, under random idling.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_tb
    import vna_pkg::*;
();

    localparam int          VCOUNT   = 1024;
    localparam int          WD_LIMIT = 40000;
    localparam logic [1:0]  OP_NONE  = 2'd3;

    typedef struct {
        logic signed [15:0] nx, ny, nz;
        logic               degen;
    } t_normal;

    class normal_scoreboard;
        logic signed [15:0] position[VCOUNT][3];
        longint             normal_sum[VCOUNT][3];
        t_normal            pending[$];
        int                 errors;

        function new();
            errors = 0;
            foreach (normal_sum[i, k]) begin
                normal_sum[i][k] = 0;
                position[i][k] = '0;
            end
        endfunction

        function longint unsigned int_sqrt(longint unsigned s);
            longint unsigned res, bt;
            res = 0;
            bt = 64'd1 << 62;
            while (bt > s) bt >>= 2;
            while (bt != 0) begin
                if (s >= res + bt) begin
                    s -= res + bt;
                    res = (res >> 1) + bt;
                end else begin
                    res >>= 1;
                end
                bt >>= 2;
            end
            return res;
        endfunction

        function t_normal unit_vector(longint v0, longint v1, longint v2);
            longint          v[3];
            longint unsigned mag[3], m, s, r, q;
            longint          n[3];
            t_normal         res;
            v[0] = v0; v[1] = v1; v[2] = v2;
            m = 0;
            s = 0;
            for (int i = 0; i < 3; i++) begin
                mag[i] = v[i] < 0 ? -v[i] : v[i];
                if (mag[i] > m) m = mag[i];
            end
            if (m == 0) begin
                res.nx = 0; res.ny = 0; res.nz = 0; res.degen = 1'b1;
                return res;
            end
            while (m >= (64'd1 << 31)) begin
                m >>= 1;
                for (int i = 0; i < 3; i++) mag[i] >>= 1;
            end
            while (m < (64'd1 << 30)) begin
                m <<= 1;
                for (int i = 0; i < 3; i++) mag[i] <<= 1;
            end
            for (int i = 0; i < 3; i++) s += mag[i] * mag[i];
            r = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = (mag[i] * 16384 + (r >> 1)) / r;
                n[i] = v[i] < 0 ? -longint'(q) : longint'(q);
            end
            res.nx = 16'(n[0]); res.ny = 16'(n[1]); res.nz = 16'(n[2]); res.degen = 1'b0;
            return res;
        endfunction

        function void note_word(logic [1:0] op, logic [IN_DATA_W-1:0] d);
            int      a, b, c;
            longint  e1[3], e2[3];
            t_normal fn;
            a = int'(d[9:0]);
            b = int'(d[19:10]);
            c = int'(d[29:20]);
            case (op)
                OP_WRITE: begin
                    position[a][0] = d[45:30];
                    position[a][1] = d[61:46];
                    position[a][2] = d[77:62];
                    for (int k = 0; k < 3; k++) normal_sum[a][k] = 0;
                end
                OP_TRIANGLE: begin
                    for (int k = 0; k < 3; k++) begin
                        e1[k] = longint'(position[b][k]) - longint'(position[a][k]);
                        e2[k] = longint'(position[c][k]) - longint'(position[a][k]);
                    end
                    fn = unit_vector(e1[1] * e2[2] - e1[2] * e2[1],
                                     e1[2] * e2[0] - e1[0] * e2[2],
                                     e1[0] * e2[1] - e1[1] * e2[0]);
                    add_face(a, fn);
                    add_face(b, fn);
                    add_face(c, fn);
                end
                OP_READ: begin
                    pending.insert(pending.size(),
                                   unit_vector(normal_sum[a][0], normal_sum[a][1],
                                               normal_sum[a][2]));
                end
                default: ;
            endcase
        endfunction

        function void add_face(int idx, t_normal fn);
            longint add[3];
            longint t;
            add[0] = fn.nx; add[1] = fn.ny; add[2] = fn.nz;
            for (int k = 0; k < 3; k++) begin
                t = normal_sum[idx][k] + add[k];
                if (t > 8388607) t = 8388607;
                if (t < -8388608) t = -8388608;
                normal_sum[idx][k] = t;
            end
        endfunction

        function void check_word(logic [OUT_DATA_W-1:0] d, logic degen);
            t_normal x;
            if (pending.size() == 0) begin
                $display("%0t: unexpected word data=%h degenerate=%b", $time, d, degen);
                errors++;
                return;
            end
            x = pending.pop_front();
            if (d !== {x.nz, x.ny, x.nx} || degen !== x.degen) begin
                $display("%0t: mismatch expected x=%0d y=%0d z=%0d deg=%b actual x=%0d y=%0d z=%0d deg=%b",
                         $time, x.nx, x.ny, x.nz, x.degen, $signed(d[15:0]),
                         $signed(d[31:16]), $signed(d[47:32]), degen);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic [1:0]            s_axis_tuser;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tuser;

    normal_scoreboard sb;
    int  send_idle_pct;
    int  recv_idle_pct;
    int  quiet_cycles = 0;
    bit  written[VCOUNT];
    int  written_list[$];

    vertex_normal_accumulator u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        if (s_axis_tvalid && s_axis_tready) sb.note_word(s_axis_tuser, s_axis_tdata);
        if (m_axis_tvalid && m_axis_tready) sb.check_word(m_axis_tdata, m_axis_tuser);
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WD_LIMIT) begin
            $display("vertex_normal_accumulator verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [15:0] rnd16();
        return 16'($urandom);
    endfunction

    task automatic send_word(logic [1:0] op, int a, int b, int c,
                             logic [15:0] px, logic [15:0] py, logic [15:0] pz);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, pz, py, px, c[9:0], b[9:0], a[9:0]};
        do @(posedge i_clk); while (!s_axis_tready);
        if (op == OP_WRITE && !written[a]) begin
            written[a] = 1'b1;
            written_list.insert(written_list.size(), a);
        end
    endtask

    task automatic go_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic random_phase(int count);
        int a, b, c, pick;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 25 || written_list.size() < 3) begin
                send_word(OP_WRITE, $urandom_range(VCOUNT - 1), $urandom_range(VCOUNT - 1),
                          $urandom_range(VCOUNT - 1), rnd16(), rnd16(), rnd16());
            end else if (pick < 65) begin
                a = written_list[$urandom_range(written_list.size() - 1)];
                b = written_list[$urandom_range(written_list.size() - 1)];
                c = written_list[$urandom_range(written_list.size() - 1)];
                send_word(OP_TRIANGLE, a, b, c, rnd16(), rnd16(), rnd16());
            end else if (pick < 95) begin
                a = ($urandom_range(1)) ? written_list[$urandom_range(written_list.size() - 1)]
                                        : $urandom_range(VCOUNT - 1);
                send_word(OP_READ, a, $urandom_range(VCOUNT - 1), $urandom_range(VCOUNT - 1),
                          rnd16(), rnd16(), rnd16());
            end else begin
                send_word(OP_NONE, $urandom_range(VCOUNT - 1), $urandom_range(VCOUNT - 1),
                          $urandom_range(VCOUNT - 1), rnd16(), rnd16(), rnd16());
            end
        end
        go_idle();
    endtask

    initial begin
        sb = new();
        send_idle_pct = 20;
        recv_idle_pct = 85;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_WRITE;
        m_axis_tready = 1'b0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_word(OP_WRITE, 0, 0, 0, 16'h7FFF, 16'h8000, 16'h0000);
        send_word(OP_WRITE, 1, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF);
        send_word(OP_WRITE, 2, 0, 0, 16'h0000, 16'h0000, 16'h8000);
        send_word(OP_WRITE, 1023, 1023, 1023, 16'hFFFF, 16'h0001, 16'h0100);
        send_word(OP_READ, 0, 0, 0, 0, 0, 0);
        send_word(OP_TRIANGLE, 0, 1, 2, 0, 0, 0);
        send_word(OP_TRIANGLE, 2, 1023, 0, 0, 0, 0);
        send_word(OP_TRIANGLE, 0, 0, 1, 0, 0, 0);
        send_word(OP_READ, 0, 0, 0, 0, 0, 0);
        send_word(OP_READ, 1, 0, 0, 0, 0, 0);
        send_word(OP_READ, 1023, 0, 0, 0, 0, 0);
        send_word(OP_READ, 512, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_NONE, 1023, 1023, 1023, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_word(OP_WRITE, 0, 0, 0, 16'h0100, 16'h0000, 16'h0000);
        send_word(OP_READ, 0, 0, 0, 0, 0, 0);
        go_idle();

        random_phase(130);
        send_idle_pct = 85;
        recv_idle_pct = 20;
        random_phase(130);
        send_idle_pct = 0;
        recv_idle_pct = 0;

        // Drive the sums of vertices 5, 6 and 7 past their saturation limit.
        send_word(OP_WRITE, 5, 0, 0, 16'h0000, 16'h0000, 16'h0000);
        send_word(OP_WRITE, 6, 0, 0, 16'h0100, 16'h0000, 16'h0000);
        send_word(OP_WRITE, 7, 0, 0, 16'h0000, 16'h0100, 16'h0000);
        for (int n = 0; n < 530; n++) send_word(OP_TRIANGLE, 5, 6, 7, 0, 0, 0);
        send_word(OP_READ, 5, 0, 0, 0, 0, 0);
        random_phase(90);

        s_axis_tvalid <= 1'b0;
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("vertex_normal_accumulator verification clean");
        end else begin
            $display("vertex_normal_accumulator verification failed");
        end
        $finish;
    end
endmodule
